>>> design/spv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spv_pkg - shared types and constants of the sensor packet validator
// Packet status codes, type code table and the words passed between stages.
// ----------------------------------------------------------------------------
package spv_pkg;

  // type code registers
  localparam int NUM_CODES = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_HUMIDITY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATE_TIME     = 3'd5;

  // reset value and expected packet length for each code register
  localparam logic [7:0] CODE_RESET [NUM_CODES] = '{8'd66, 8'd65, 8'd70, 8'd72, 8'd71, 8'd96};
  localparam logic [7:0] CODE_LEN   [NUM_CODES] = '{8'd12, 8'd17, 8'd8, 8'd11, 8'd6, 8'd12};

  localparam logic [7:0] MIN_PACKET = 8'd4;
  localparam logic [7:0] COUNT_MAX  = 8'hFF;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_CHECKSUM = 3'd2;
  localparam logic [2:0] ST_TYPE     = 3'd3;
  localparam logic [2:0] ST_LENGTH   = 3'd4;

  typedef logic [7:0] code_arr_t [NUM_CODES];

  // summary of one finished packet, front to back
  typedef struct packed {
    logic [15:0] sum;
    logic [15:0] wire_sum;
    logic [7:0]  ptype;
    logic [7:0]  flags;
    logic [7:0]  total;
  } pkt_sum_t;

  // one status result
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] ptype;
    logic [7:0] flags;
    logic [7:0] total;
  } res_t;

  // queue handshake between front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

>>> design/spv_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spv_front - byte accumulator
// Takes packet bytes, keeps the running sum, delay line, count and header
// bytes, and pushes a packet summary word on the final byte.
// ----------------------------------------------------------------------------
module spv_front import spv_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] byte_in,
  input  wire logic       last_byte,
  input  wire logic       accept,
  output pkt_sum_t        sum_word,
  output logic            sum_push
);

  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  delayed_one, delayed_two;
  logic [7:0]  byte_counter, byte_counter_next;
  logic [7:0]  held_type, held_type_next;
  logic [7:0]  held_flags, held_flags_next;

  // next packet state for this byte
  always_comb begin
    held_flags_next   = (byte_counter == 8'd0) ? byte_in : held_flags;
    held_type_next    = (byte_counter == 8'd1) ? byte_in : held_type;
    running_sum_next  = (|byte_counter[7:1]) ? running_sum + {8'd0, delayed_two}
                                             : running_sum;
    byte_counter_next = (byte_counter == COUNT_MAX) ? byte_counter : byte_counter + 8'd1;
  end

  // summary word on the final byte
  assign sum_push          = accept && last_byte;
  assign sum_word.sum      = running_sum_next;
  assign sum_word.wire_sum = {byte_in, delayed_one};
  assign sum_word.ptype    = held_type_next;
  assign sum_word.flags    = held_flags_next;
  assign sum_word.total    = byte_counter_next;

  // packet state registers, cleared at end of packet
  always_ff @(posedge clk) begin
    if (rst || sum_push) begin
      running_sum  <= '0;
      delayed_one  <= '0;
      delayed_two  <= '0;
      byte_counter <= '0;
      held_type    <= '0;
      held_flags   <= '0;
    end else if (accept) begin
      running_sum  <= running_sum_next;
      delayed_one  <= byte_in;
      delayed_two  <= delayed_one;
      byte_counter <= byte_counter_next;
      held_type    <= held_type_next;
      held_flags   <= held_flags_next;
    end
  end

endmodule
`default_nettype wire

>>> design/spv_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spv_queue - two-entry summary queue
// Decouples the byte accumulator from the status stage.
// ----------------------------------------------------------------------------
module spv_queue import spv_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire pkt_sum_t wr_word,
  input  wire logic     wr_en,
  input  wire logic     rd_en,
  output pkt_sum_t      rd_word,
  output q_stat_t       stat
);

  pkt_sum_t   entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);
  assign rd_word    = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_word;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && stat.full))
    else $error("summary word written into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && stat.empty))
    else $error("summary word read from empty queue");
`endif

endmodule
`default_nettype wire

>>> design/spv_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spv_back - status stage and result buffer
// Classifies each packet summary and holds results until they are taken.
// ----------------------------------------------------------------------------
module spv_back import spv_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire code_arr_t codes,
  input  wire pkt_sum_t  sum_word,
  input  wire q_stat_t   q_stat,
  output logic           q_pop,
  output res_t           head,
  output logic           res_empty,
  input  wire logic      res_pop
);

  res_t       res_buf [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       found;
  logic [7:0] expect_len;
  res_t       res_new;
  logic       res_take;

  // type lookup, first matching register wins
  always_comb begin
    found      = 1'b0;
    expect_len = 8'd0;
    for (int i = NUM_CODES - 1; i >= 0; i--) begin
      if (codes[i] == sum_word.ptype) begin
        found      = 1'b1;
        expect_len = CODE_LEN[i];
      end
    end
  end

  // checks in priority order
  always_comb begin
    res_new.ptype = sum_word.ptype;
    res_new.flags = sum_word.flags;
    res_new.total = sum_word.total;
    priority if (sum_word.total < MIN_PACKET)        res_new.status = ST_SHORT;
    else if (sum_word.sum != sum_word.wire_sum)      res_new.status = ST_CHECKSUM;
    else if (!found)                                 res_new.status = ST_TYPE;
    else if (sum_word.total != expect_len)           res_new.status = ST_LENGTH;
    else                                             res_new.status = ST_OK;
  end

  // result buffer handshake
  assign res_empty = (count == 2'd0);
  assign res_take  = res_pop && !res_empty;
  assign q_pop     = !q_stat.empty && ((count != 2'd2) || res_take);
  assign head      = res_buf[rd_ptr];

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_buf[wr_ptr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (q_pop)    wr_ptr <= ~wr_ptr;
      if (res_take) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, q_pop} - {1'b0, res_take};
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer count out of range");
  a_short_status: assert property (@(posedge clk) disable iff (rst)
    !res_empty |-> ((head.status == ST_SHORT) == (head.total < MIN_PACKET)))
    else $error("short status disagrees with byte count");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    !res_empty |-> (head.status == ST_OK || head.status == ST_SHORT ||
                    head.status == ST_CHECKSUM || head.status == ST_TYPE ||
                    head.status == ST_LENGTH))
    else $error("result word carries undefined status");
`endif

endmodule
`default_nettype wire

>>> design/sensor_packet_validator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_packet_validator_top - weather sensor packet checker
// Checks length, checksum and type of byte-serial sensor packets.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive byte_in/last_byte with push; a word is taken at an edge
//   where push is high and full is low. One byte per cycle is sustained while full stays low.
//   Result queue: while empty is low, status/packet_type/flags_byte/byte_total
//   hold the oldest result; pop takes it. One result per packet, made on the
//   word flagged last_byte.
//   Result path: the summary of the final byte is registered in the summary queue,
//   then its result in the result buffer, where it becomes visible.
//   Throughput: one byte per cycle while full is low; the running sum is one 16-bit add per byte.
//   Configuration: cfg_we writes cfg_data into type code register cfg_addr;
//   indexes beyond the list are ignored. Write only while idle.
//   Reset: rst (synchronous) clears packet state and both queues and loads the
//   default type codes.
//   Stall: a held-off receiver fills the result buffer (two results) and then
//   the summary queue (two packets); full then rises and every byte is refused
//   until the status stage frees a queue entry.
// ----------------------------------------------------------------------------
module sensor_packet_validator_top import spv_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [7:0]           byte_in,
  input  wire logic                 last_byte,
  input  wire logic                 push,
  output logic                      full,
  output logic [2:0]                status,
  output logic [7:0]                packet_type,
  output logic [7:0]                flags_byte,
  output logic [7:0]                byte_total,
  output logic                      empty,
  input  wire logic                 pop,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [7:0]           cfg_data
);

  code_arr_t codes;
  pkt_sum_t  front_word, back_word;
  logic      front_push, q_pop, accept;
  q_stat_t   q_stat;
  res_t      head;

  // type code registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CODES; i++) codes[i] <= CODE_RESET[i];
    end else if (cfg_we && cfg_addr <= REG_DATE_TIME) begin
      codes[cfg_addr] <= cfg_data;
    end
  end

  // a byte can be refused only when the summary queue is full
  assign full   = q_stat.full;
  assign accept = push && !full;

  spv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_in),
    .last_byte (last_byte),
    .accept    (accept),
    .sum_word  (front_word),
    .sum_push  (front_push)
  );

  spv_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_word (front_word),
    .wr_en   (front_push),
    .rd_en   (q_pop),
    .rd_word (back_word),
    .stat    (q_stat)
  );

  spv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .codes     (codes),
    .sum_word  (back_word),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .head      (head),
    .res_empty (empty),
    .res_pop   (pop)
  );

  assign status      = head.status;
  assign packet_type = head.ptype;
  assign flags_byte  = head.flags;
  assign byte_total  = head.total;

endmodule
`default_nettype wire

>>> tb/spv_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spv_result_checker - scoreboard for the sensor packet validator
// Follows every accepted byte and type code write, works out the status word
// each packet should end in and compares it field by field with what is popped.
// ----------------------------------------------------------------------------
module spv_result_checker import spv_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [7:0]           byte_in,
  input  wire logic                 last_byte,
  input  wire logic                 push,
  input  wire logic                 full,
  input  wire logic [2:0]           status,
  input  wire logic [7:0]           packet_type,
  input  wire logic [7:0]           flags_byte,
  input  wire logic [7:0]           byte_total,
  input  wire logic                 empty,
  input  wire logic                 pop,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [7:0]           cfg_data,
  output int                        fail_count,
  output int                        results_owed,
  output logic [4:0][15:0]          status_seen
);

  // packet length each type code register stands for, and its value out of reset
  localparam logic [7:0] LEN_FOR_CODE [NUM_CODES] =
    '{8'd12, 8'd17, 8'd8, 8'd11, 8'd6, 8'd12};
  localparam logic [7:0] CODES_AT_RESET [NUM_CODES] =
    '{8'd66, 8'd65, 8'd70, 8'd72, 8'd71, 8'd96};
  localparam logic [7:0] SHORTEST  = 8'd4;
  localparam logic [7:0] COUNT_TOP = 8'hFF;

  logic [7:0]       type_code [NUM_CODES];
  logic [15:0]      byte_sum;
  logic [7:0]       prev_byte;
  logic [7:0]       prev_prev_byte;
  logic [7:0]       bytes_in_packet;
  logic [7:0]       type_seen;
  logic [7:0]       flags_seen;
  res_t             awaited_status_q [$];
  int               failures = 0;
  logic [4:0][15:0] tally = '0;

  initial begin
    fail_count   = 0;
    results_owed = 0;
    status_seen  = '0;
  end

  function automatic void clear_packet();
    byte_sum        = '0;
    prev_byte       = '0;
    prev_prev_byte  = '0;
    bytes_in_packet = '0;
    type_seen       = '0;
    flags_seen      = '0;
  endfunction

  // one accepted byte; the final byte of a packet queues its status word
  function automatic void absorb_byte(input logic [7:0] b, input logic is_last);
    logic [15:0] sent_sum;
    logic [7:0]  want_len;
    logic        known;
    res_t        word;
    if (bytes_in_packet == 8'd0) begin
      flags_seen = b;
    end else if (bytes_in_packet == 8'd1) begin
      type_seen = b;
    end
    // byte leaving the two-deep delay can no longer be a checksum byte
    if (bytes_in_packet >= 8'd2) begin
      byte_sum = byte_sum + {8'd0, prev_prev_byte};
    end
    sent_sum        = {b, prev_byte};
    prev_prev_byte  = prev_byte;
    prev_byte       = b;
    if (bytes_in_packet != COUNT_TOP) begin
      bytes_in_packet = bytes_in_packet + 8'd1;
    end
    if (is_last) begin
      // first register holding the code decides the length
      known    = 1'b0;
      want_len = '0;
      for (int i = 0; i < NUM_CODES; i++) begin
        if (!known && type_code[i] == type_seen) begin
          known    = 1'b1;
          want_len = LEN_FOR_CODE[i];
        end
      end
      if (bytes_in_packet < SHORTEST) begin
        word.status = ST_SHORT;
      end else if (byte_sum != sent_sum) begin
        word.status = ST_CHECKSUM;
      end else if (!known) begin
        word.status = ST_TYPE;
      end else if (bytes_in_packet != want_len) begin
        word.status = ST_LENGTH;
      end else begin
        word.status = ST_OK;
      end
      word.ptype = type_seen;
      word.flags = flags_seen;
      word.total = bytes_in_packet;
      awaited_status_q.push_back(word);
      clear_packet();
    end
  endfunction

  // popped status word against the oldest packet still owed
  function automatic void compare_status();
    res_t want;
    if (awaited_status_q.size() == 0) begin
      $error("status word popped with no packet owed: status %0d, type %0d",
             status, packet_type);
      failures++;
    end else begin
      want = awaited_status_q.pop_front();
      tally[want.status] = tally[want.status] + 16'd1;
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        failures++;
      end
      if (packet_type !== want.ptype) begin
        $error("packet_type: expected %0d, got %0d", want.ptype, packet_type);
        failures++;
      end
      if (flags_byte !== want.flags) begin
        $error("flags_byte: expected %0d, got %0d", want.flags, flags_byte);
        failures++;
      end
      if (byte_total !== want.total) begin
        $error("byte_total: expected %0d, got %0d", want.total, byte_total);
        failures++;
      end
    end
  endfunction

  // watch all three ports at each edge; counts go out registered
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CODES; i++) begin
        type_code[i] = CODES_AT_RESET[i];
      end
      clear_packet();
      awaited_status_q.delete();
    end else begin
      if (pop && !empty) begin
        compare_status();
      end
      if (push && !full) begin
        absorb_byte(byte_in, last_byte);
      end
      // writes past the register list are dropped
      if (cfg_we && cfg_addr < NUM_CODES) begin
        type_code[cfg_addr] = cfg_data;
      end
    end
    fail_count   <= failures;
    results_owed <= awaited_status_q.size();
    status_seen  <= tally;
  end

endmodule

>>> tb/tb_sensor_packet_validator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sensor_packet_validator_top - testbench for the sensor packet validator
// Sends directed and random byte-serial packets under several type code
// settings, with random gaps on both sides, a long result hold-off and a
// stretch at full rate; the checker module scores every status word.
// ----------------------------------------------------------------------------
module tb_sensor_packet_validator_top;
  import spv_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_BYTES   = 345;
  localparam int IDLE_PERCENT  = 31;

  // type code register indexes not named in the package, plus two spare ones
  localparam logic [CFG_IDX_W-1:0] REG_RAIN         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AIR_PRESSURE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIND         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UV           = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B      = 3'd7;

  localparam logic [7:0] DEFAULT_CODE [NUM_CODES] =
    '{8'd66, 8'd65, 8'd70, 8'd72, 8'd71, 8'd96};
  localparam logic [7:0] EXPECTED_LEN [NUM_CODES] =
    '{8'd12, 8'd17, 8'd8, 8'd11, 8'd6, 8'd12};

  typedef enum logic [1:0] {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic [7:0]           byte_in   = '0;
  logic                 last_byte = 1'b0;
  logic                 push      = 1'b0;
  logic                 pop       = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr  = '0;
  logic [7:0]           cfg_data  = '0;
  logic                 full;
  logic                 empty;
  logic [2:0]           status;
  logic [7:0]           packet_type;
  logic [7:0]           flags_byte;
  logic [7:0]           byte_total;

  logic                 hold_req  = 1'b0;
  logic                 rx_steady = 1'b0;
  bit                   tx_steady = 1'b0;
  int                   hold_left = 0;
  int                   quiet_cycles = 0;
  int                   bytes_sent = 0;
  int                   packets_sent = 0;
  logic [7:0]           code_now [NUM_CODES];

  int                   fail_count;
  int                   results_owed;
  logic [4:0][15:0]     status_seen;

  always #6 clk = ~clk;

  sensor_packet_validator_top u_top (
    .clk         (clk),
    .rst         (rst),
    .byte_in     (byte_in),
    .last_byte   (last_byte),
    .push        (push),
    .full        (full),
    .status      (status),
    .packet_type (packet_type),
    .flags_byte  (flags_byte),
    .byte_total  (byte_total),
    .empty       (empty),
    .pop         (pop),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data)
  );

  spv_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .byte_in      (byte_in),
    .last_byte    (last_byte),
    .push         (push),
    .full         (full),
    .status       (status),
    .packet_type  (packet_type),
    .flags_byte   (flags_byte),
    .byte_total   (byte_total),
    .empty        (empty),
    .pop          (pop),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_owed (results_owed),
    .status_seen  (status_seen)
  );

  // result side: random pops, or a counted hold-off when asked for one
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      pop       <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      pop       <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_req  <= 1'b0;
    end else begin
      pop <= rx_steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // watchdog: too long without any word moving on any port
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // length of the first register that holds this code, zero when none does
  function automatic logic [7:0] packet_len_for(input logic [7:0] code);
    logic [7:0] len;
    len = '0;
    for (int i = NUM_CODES - 1; i >= 0; i--) begin
      if (code_now[i] == code) begin
        len = EXPECTED_LEN[i];
      end
    end
    return len;
  endfunction

  // offer one byte, with random gaps before it, until it is taken
  task automatic send_word(input logic [7:0] value, input logic is_last);
    while (!tx_steady && $urandom_range(99) < IDLE_PERCENT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    byte_in   <= value;
    last_byte <= is_last;
    @(posedge clk);
    while (full) begin
      @(posedge clk);
    end
    bytes_sent++;
  endtask

  // build a packet: flags, type, body, then little-endian sum unless short
  task automatic send_packet(input int len, input logic [7:0] ptype,
                             input bit corrupt, input fill_t fill);
    logic [7:0]  pkt [$];
    logic [15:0] sum;
    logic [15:0] check;
    logic [7:0]  b;
    int          body;
    sum  = '0;
    body = (len >= 4) ? len - 2 : len;
    for (int i = 0; i < body; i++) begin
      case (fill)
        FILL_ONES:  b = 8'hFF;
        FILL_ZEROS: b = 8'h00;
        default:    b = 8'($urandom_range(255));
      endcase
      if (i == 1) begin
        b = ptype;
      end
      pkt.push_back(b);
      sum = sum + {8'd0, b};
    end
    if (len >= 4) begin
      check = corrupt ? sum ^ 16'($urandom_range(16'hFFFF, 1)) : sum;
      pkt.push_back(check[7:0]);
      pkt.push_back(check[15:8]);
    end
    for (int i = 0; i < len; i++) begin
      send_word(pkt[i], i == len - 1);
    end
    packets_sent++;
  endtask

  // mostly well-formed packets of a configured type, the rest broken
  task automatic send_random_packet();
    int         roll;
    int         len;
    int         fill_roll;
    logic [7:0] ptype;
    fill_t      fill;
    roll  = $urandom_range(99);
    ptype = code_now[3'($urandom_range(NUM_CODES - 1))];
    len   = packet_len_for(ptype);
    if (roll >= 96) begin
      ptype = 8'($urandom_range(255));
      len   = $urandom_range(40, 4);
    end else if (roll >= 90) begin
      len = $urandom_range(3, 1);
    end else if (roll >= 80) begin
      ptype = 8'($urandom_range(255));
      len   = $urandom_range(20, 4);
    end else if (roll >= 70) begin
      len = $urandom_range(20, 4);
    end
    fill_roll = $urandom_range(19);
    fill = (fill_roll == 0) ? FILL_ONES : (fill_roll == 1) ? FILL_ZEROS : FILL_RANDOM;
    send_packet(len, ptype, $urandom_range(99) < 12, fill);
  endtask

  task automatic random_phase();
    int stop_at;
    stop_at = bytes_sent + PHASE_BYTES;
    while (bytes_sent < stop_at) begin
      send_random_packet();
    end
  endtask

  // stop sending and wait until every owed status word has been popped
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_code(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    if (idx < NUM_CODES) begin
      code_now[idx] = value;
    end
    @(posedge clk);
  endtask

  // all six type codes, then junk into the unused indexes
  task automatic program_codes(input logic [7:0] th, input logic [7:0] rain,
                               input logic [7:0] press, input logic [7:0] wind,
                               input logic [7:0] uv, input logic [7:0] dt);
    write_code(REG_TEMP_HUMIDITY, th);
    write_code(REG_RAIN, rain);
    write_code(REG_AIR_PRESSURE, press);
    write_code(REG_WIND, wind);
    write_code(REG_UV, uv);
    write_code(REG_DATE_TIME, dt);
    write_code(REG_SPARE_A, 8'($urandom_range(255)));
    write_code(REG_SPARE_B, 8'($urandom_range(255)));
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [7:0] same_code;
    for (int i = 0; i < NUM_CODES; i++) begin
      code_now[i] = DEFAULT_CODE[i];
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: short packets, extreme bytes, each failing check, reset codes
    send_packet(1, 8'h00, 1'b0, FILL_ONES);
    send_packet(2, 8'hFF, 1'b0, FILL_RANDOM);
    send_packet(3, 8'h00, 1'b0, FILL_ZEROS);
    send_packet(6, code_now[REG_UV], 1'b0, FILL_ONES);
    send_packet(6, code_now[REG_UV], 1'b1, FILL_ZEROS);
    send_packet(4, 8'h00, 1'b0, FILL_RANDOM);
    send_packet(6, code_now[REG_AIR_PRESSURE], 1'b0, FILL_RANDOM);

    // long packets: counter saturation, and a large all-ones sum
    send_packet(255, code_now[REG_TEMP_HUMIDITY], 1'b0, FILL_RANDOM);
    send_packet(258, code_now[REG_WIND], 1'b0, FILL_ONES);
    drain_results();

    // random codes; the result side holds off while packets keep coming
    program_codes(8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)));
    hold_req <= 1'b1;
    repeat (8) send_packet(4, 8'($urandom_range(255)), 1'b0, FILL_RANDOM);
    random_phase();
    drain_results();

    // extreme codes, two pairs shared so the first register must win
    program_codes(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h01);
    random_phase();
    drain_results();

    // one code in every register, both sides at full rate
    same_code = 8'($urandom_range(255));
    program_codes(same_code, same_code, same_code, same_code, same_code, same_code);
    tx_steady = 1'b1;
    rx_steady <= 1'b1;
    random_phase();
    tx_steady = 1'b0;
    rx_steady <= 1'b0;
    drain_results();

    // back to the reset codes, written explicitly
    program_codes(DEFAULT_CODE[REG_TEMP_HUMIDITY], DEFAULT_CODE[REG_RAIN],
                  DEFAULT_CODE[REG_AIR_PRESSURE], DEFAULT_CODE[REG_WIND],
                  DEFAULT_CODE[REG_UV], DEFAULT_CODE[REG_DATE_TIME]);
    random_phase();
    drain_results();

    $display("covered %0d bytes in %0d packets over five type code settings,",
             bytes_sent, packets_sent);
    $display("  statuses: %0d ok, %0d short, %0d checksum, %0d unknown type, %0d length",
             status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_CHECKSUM],
             status_seen[ST_TYPE], status_seen[ST_LENGTH]);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
